FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/owt_pkg.sv
`timescale 1ns / 1ps

package owt_pkg;

   // Scale format: unsigned fixed point, SCALE_FRAC_BITS fraction bits.
   localparam int unsigned SCALE_FRAC_BITS = 13;
   localparam int unsigned ONE_RAW         = 1 << SCALE_FRAC_BITS;
   localparam logic [15:0] SCALE_ONE       = (ONE_RAW > 65535) ? 16'hFFFF : 16'(ONE_RAW);
   localparam logic [15:0] SCALE_STEP      = 16'((ONE_RAW * 15 + 50) / 100);

   // Primary thresholds are counted in units of the primary base.
   localparam int unsigned PRI_BASE_SHIFT = 13;
   localparam logic [12:0] PRI_ALARM_UNIT = 13'h1600;
   localparam logic [12:0] PRI_PANIC_UNIT = 13'h1D00;
   localparam logic [31:0] PEAK_BOUND     = 32'h1000_0000;

   localparam logic [17:0] PRI_LIMIT_MIN = 18'd8192;
   localparam logic [18:0] SEC_LIMIT_MIN = 19'd16384;

   // Commands
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_PRIMARY_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_SECONDARY_ENABLE = 2'd1;
   localparam logic [1:0] CSR_PRIMARY_LIMIT    = 2'd2;
   localparam logic [1:0] CSR_SECONDARY_LIMIT  = 2'd3;

   typedef struct packed {
      logic primary_over_limit;
      logic overflow_first;
      logic secondary_full_first;
      logic secondary_step;
      logic primary_emergency;
      logic primary_step;
   } flags_type;

   typedef struct packed {
      logic [15:0] scale_out;
      logic [15:0] ceiling_value;
      logic        ceiling_unset;
      logic [31:0] primary_peak;
      logic [20:0] secondary_peak;
      flags_type   flags;
   } rsp_type;

   // Step the scale down, never below one; only called with s above one.
   function automatic logic [15:0] step_down(input logic [15:0] s);
      logic [15:0] diff;
      diff = s - SCALE_ONE;
      if (diff <= SCALE_STEP) begin
         return SCALE_ONE;
      end
      return s - SCALE_STEP;
   endfunction

endpackage

FILE: hdl/occupancy_watchdog_throttle.sv
`timescale 1ns / 1ps
// Channel    Handshake            Payload
// ---------  -------------------  ---------------------------------------------
// req        req_valid/req_stall  cmd, primary_used, secondary_used, scale_in
// rsp        rsp_valid/rsp_stall  scale_out, ceiling, peaks, six event flags
// csr        csr_write_enable     csr_index, csr_write_data (no read-back)
//
// One word per cycle sustained while rsp is not stalled; a taken word reaches rsp via both.
// The input register and the result register are the only stages; all of the
// threshold, step and ceiling logic sits between them and updates state once per word.
// Synchronous reset clears the valid bits, sticky flags and peaks, and resets config.
// A stalled result holds its register; req_stall rises only while both stages are full.
`include "assert_macros.svh"

module occupancy_watchdog_throttle #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_cmd,
   input  logic [31:0]          req_primary_used,
   input  logic [31:0]          req_secondary_used,
   input  logic [15:0]          req_scale_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [15:0]          rsp_scale_out,
   output logic [15:0]          rsp_ceiling_value,
   output logic                 rsp_ceiling_unset,
   output logic [31:0]          rsp_primary_peak,
   output logic [20:0]          rsp_secondary_peak,
   output logic                 rsp_primary_over_limit,
   output logic                 rsp_overflow_first,
   output logic                 rsp_secondary_full_first,
   output logic                 rsp_secondary_step,
   output logic                 rsp_primary_emergency,
   output logic                 rsp_primary_step,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [18:0]          csr_write_data
);
   import owt_pkg::*;

   // Configuration
   logic        primary_enable_ff;
   logic        secondary_enable_ff;
   logic [17:0] primary_limit_ff;
   logic [18:0] secondary_limit_ff;

   // Input stage
   logic                   a_valid_ff, a_valid_in;
   logic                   a_cmd_ff;
   logic [COUNT_WIDTH-1:0] a_pu_ff;
   logic [COUNT_WIDTH-1:0] a_su_ff;
   logic [15:0]            a_scale_ff;

   // Result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Watchdog state
   logic                   overflow_seen_ff, overflow_seen_in;
   logic                   sec_full_seen_ff, sec_full_seen_in;
   logic [COUNT_WIDTH-1:0] pri_peak_ff, pri_peak_in;
   logic [20:0]            sec_peak_ff, sec_peak_in;
   logic [15:0]            ceiling_ff, ceiling_in;
   logic                   ceiling_unset_ff, ceiling_unset_in;

   logic req_fire;
   logic a_fire;

   // Thresholds derived from the limits
   logic [4:0]  pri_units;
   logic [17:0] pri_alarm;
   logic [17:0] pri_panic;
   logic [20:0] sec_triple;
   logic [20:0] sec_alarm;
   logic [20:0] sec_cap;
   logic [31:0] pu32;
   logic [31:0] su32;
   logic [15:0] scale;
   flags_type   flags;

   // ---------------------------------------------------------------- handshake
   assign req_stall = a_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign a_fire    = a_valid_ff && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_fire) begin
         a_valid_in = 1'b1;
      end else if (a_fire) begin
         a_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (a_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         primary_enable_ff   <= 1'b0;
         secondary_enable_ff <= 1'b0;
         primary_limit_ff    <= PRI_LIMIT_MIN;
         secondary_limit_ff  <= SEC_LIMIT_MIN;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PRIMARY_ENABLE: begin
               primary_enable_ff <= csr_write_data[0];
            end
            CSR_SECONDARY_ENABLE: begin
               secondary_enable_ff <= csr_write_data[0];
            end
            CSR_PRIMARY_LIMIT: begin
               // drop limits below the minimum
               if (csr_write_data[17:0] >= PRI_LIMIT_MIN) begin
                  primary_limit_ff <= csr_write_data[17:0];
               end
            end
            CSR_SECONDARY_LIMIT: begin
               if (csr_write_data >= SEC_LIMIT_MIN) begin
                  secondary_limit_ff <= csr_write_data;
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- thresholds
   // Primary thresholds count whole base units of the limit; the secondary
   // alarm sits at three quarters of its limit, and counts beyond four times
   // the limit are treated as garbage.
   assign pri_units  = primary_limit_ff[17:PRI_BASE_SHIFT];
   assign pri_alarm  = 18'(pri_units) * 18'(PRI_ALARM_UNIT);
   assign pri_panic  = 18'(pri_units) * 18'(PRI_PANIC_UNIT);
   assign sec_triple = 21'({2'b00, secondary_limit_ff}) + 21'({1'b0, secondary_limit_ff, 1'b0});
   assign sec_alarm  = sec_triple >> 2;
   assign sec_cap    = {secondary_limit_ff, 2'b00};
   assign pu32       = 32'(a_pu_ff);
   assign su32       = 32'(a_su_ff);

   // ---------------------------------------------------------------- tick logic
   always_comb begin
      overflow_seen_in = overflow_seen_ff;
      sec_full_seen_in = sec_full_seen_ff;
      pri_peak_in      = pri_peak_ff;
      sec_peak_in      = sec_peak_ff;
      ceiling_in       = ceiling_ff;
      ceiling_unset_in = ceiling_unset_ff;
      scale            = a_scale_ff;
      flags            = '0;

      if (a_cmd_ff == CMD_CLEAR) begin
         ceiling_unset_in = 1'b1;
      end else if (primary_enable_ff) begin
         if (pu32 > 32'(primary_limit_ff)) begin
            // Primary overflow: clamp, mark, skip the alarms.
            flags.primary_over_limit = 1'b1;
            if (!overflow_seen_ff) begin
               overflow_seen_in     = 1'b1;
               flags.overflow_first = 1'b1;
            end
            if (scale > SCALE_ONE) begin
               scale            = SCALE_ONE;
               ceiling_in       = SCALE_ONE;
               ceiling_unset_in = 1'b0;
            end
            if (a_pu_ff > pri_peak_ff && pu32 < PEAK_BOUND) begin
               pri_peak_in = a_pu_ff;
            end
         end else begin
            if (a_pu_ff > pri_peak_ff) begin
               pri_peak_in = a_pu_ff;
            end
            if (secondary_enable_ff && su32 <= 32'(sec_cap)) begin
               if (su32 > 32'(sec_peak_ff)) begin
                  sec_peak_in = su32[20:0];
               end
               if (su32 >= 32'(secondary_limit_ff) && !sec_full_seen_ff) begin
                  // one-time clamp, even from below one
                  sec_full_seen_in           = 1'b1;
                  flags.secondary_full_first = 1'b1;
                  scale                      = SCALE_ONE;
                  ceiling_in                 = SCALE_ONE;
                  ceiling_unset_in           = 1'b0;
               end else if (su32 >= 32'(sec_alarm) && scale > SCALE_ONE) begin
                  scale                = step_down(scale);
                  ceiling_in           = scale;
                  ceiling_unset_in     = 1'b0;
                  flags.secondary_step = 1'b1;
               end
            end
            // Primary checks see the scale after any secondary brake.
            if (pu32 >= 32'(pri_panic) && scale > SCALE_ONE) begin
               scale                   = SCALE_ONE;
               ceiling_in              = SCALE_ONE;
               ceiling_unset_in        = 1'b0;
               flags.primary_emergency = 1'b1;
            end else if (pu32 >= 32'(pri_alarm) && scale > SCALE_ONE) begin
               scale              = step_down(scale);
               ceiling_in         = scale;
               ceiling_unset_in   = 1'b0;
               flags.primary_step = 1'b1;
            end
         end
      end

      rsp_in.scale_out      = scale;
      rsp_in.ceiling_value  = ceiling_unset_in ? 16'd0 : ceiling_in;
      rsp_in.ceiling_unset  = ceiling_unset_in;
      rsp_in.primary_peak   = 32'(pri_peak_in);
      rsp_in.secondary_peak = sec_peak_in;
      rsp_in.flags          = flags;
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         overflow_seen_ff <= 1'b0;
         sec_full_seen_ff <= 1'b0;
         pri_peak_ff      <= '0;
         sec_peak_ff      <= '0;
         ceiling_ff       <= '0;
         ceiling_unset_ff <= 1'b1;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // advance state only as a word moves into the result register
         if (a_fire) begin
            overflow_seen_ff <= overflow_seen_in;
            sec_full_seen_ff <= sec_full_seen_in;
            pri_peak_ff      <= pri_peak_in;
            sec_peak_ff      <= sec_peak_in;
            ceiling_ff       <= ceiling_in;
            ceiling_unset_ff <= ceiling_unset_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_cmd_ff   <= req_cmd;
         a_pu_ff    <= req_primary_used[COUNT_WIDTH-1:0];
         a_su_ff    <= req_secondary_used[COUNT_WIDTH-1:0];
         a_scale_ff <= req_scale_in;
      end
      if (a_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_scale_out            = rsp_ff.scale_out;
   assign rsp_ceiling_value        = rsp_ff.ceiling_value;
   assign rsp_ceiling_unset        = rsp_ff.ceiling_unset;
   assign rsp_primary_peak         = rsp_ff.primary_peak;
   assign rsp_secondary_peak       = rsp_ff.secondary_peak;
   assign rsp_primary_over_limit   = rsp_ff.flags.primary_over_limit;
   assign rsp_overflow_first       = rsp_ff.flags.overflow_first;
   assign rsp_secondary_full_first = rsp_ff.flags.secondary_full_first;
   assign rsp_secondary_step       = rsp_ff.flags.secondary_step;
   assign rsp_primary_emergency    = rsp_ff.flags.primary_emergency;
   assign rsp_primary_step         = rsp_ff.flags.primary_step;

   // ---------------------------------------------------------------- checks
   `ASSERT_SAME(a_no_ceiling_zero, clock, reset, rsp_valid && rsp_ceiling_unset, rsp_ceiling_value == 16'd0, "ceiling value nonzero with no ceiling")
   `ASSERT_SAME(a_primary_exclusive, clock, reset, rsp_valid, !(rsp_primary_emergency && rsp_primary_step), "primary panic and step together")
   `ASSERT_SAME(a_first_needs_over, clock, reset, rsp_valid && rsp_overflow_first, rsp_primary_over_limit, "first overflow without overflow")
   `ASSERT_SAME(a_seen_rises_with_word, clock, reset, $rose(overflow_seen_ff), rsp_valid && rsp_overflow_first, "overflow mark set without a reporting word")
endmodule

FILE: sim/owt_result_check.sv
`timescale 1ns / 1ps

module owt_result_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_primary_used,
   input  logic [31:0] req_secondary_used,
   input  logic [15:0] req_scale_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_scale_out,
   input  logic [15:0] rsp_ceiling_value,
   input  logic        rsp_ceiling_unset,
   input  logic [31:0] rsp_primary_peak,
   input  logic [20:0] rsp_secondary_peak,
   input  logic        rsp_primary_over_limit,
   input  logic        rsp_overflow_first,
   input  logic        rsp_secondary_full_first,
   input  logic        rsp_secondary_step,
   input  logic        rsp_primary_emergency,
   input  logic        rsp_primary_step,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [18:0] csr_write_data,
   output int unsigned mismatches,
   output int unsigned pending
);

   import owt_pkg::*;

   // Shadow copy of the throttle: configuration and sticky state.
   logic        pri_enable;
   logic        sec_enable;
   logic [17:0] pri_limit;
   logic [18:0] sec_limit;
   logic        overflow_seen;
   logic        sec_full_seen;
   logic [31:0] pri_peak;
   logic [20:0] sec_peak;
   logic [15:0] ceiling;
   logic        no_ceiling;

   rsp_type expected_throttle[$];
   rsp_type predicted;
   rsp_type oldest;

   function automatic logic [15:0] lower_scale(input logic [15:0] s);
      return (s > SCALE_ONE + SCALE_STEP) ? s - SCALE_STEP : SCALE_ONE;
   endfunction

   task automatic impose_ceiling(input logic [15:0] s);
      ceiling = s;
      no_ceiling = 1'b0;
   endtask

   task automatic predict_throttle(input logic cmd, input logic [31:0] pu,
                                   input logic [31:0] su, input logic [15:0] scale_in,
                                   output rsp_type word);
      logic [15:0] scale;
      logic [31:0] units;
      logic [31:0] alarm;
      logic [31:0] panic;
      logic [31:0] sec_alarm;
      scale = scale_in;
      word = '0;
      if (cmd == CMD_CLEAR) begin
         no_ceiling = 1'b1;
      end else if (pri_enable) begin
         if (pu > 32'(pri_limit)) begin
            word.flags.primary_over_limit = 1'b1;
            if (!overflow_seen) begin
               overflow_seen = 1'b1;
               word.flags.overflow_first = 1'b1;
            end
            if (scale > SCALE_ONE) begin
               scale = SCALE_ONE;
               impose_ceiling(scale);
            end
            if (pu > pri_peak && pu < PEAK_BOUND) begin
               pri_peak = pu;
            end
         end else begin
            if (pu > pri_peak) begin
               pri_peak = pu;
            end
            // counts above four times the limit are treated as garbage
            if (sec_enable && su <= 32'(sec_limit) * 32'd4) begin
               sec_alarm = (32'(sec_limit) * 32'd3) >> 2;
               if (su > 32'(sec_peak)) begin
                  sec_peak = su[20:0];
               end
               if (su >= 32'(sec_limit) && !sec_full_seen) begin
                  sec_full_seen = 1'b1;
                  word.flags.secondary_full_first = 1'b1;
                  scale = SCALE_ONE;
                  impose_ceiling(scale);
               end else if (su >= sec_alarm && scale > SCALE_ONE) begin
                  scale = lower_scale(scale);
                  impose_ceiling(scale);
                  word.flags.secondary_step = 1'b1;
               end
            end
            units = 32'(pri_limit) >> PRI_BASE_SHIFT;
            alarm = units * 32'(PRI_ALARM_UNIT);
            panic = units * 32'(PRI_PANIC_UNIT);
            if (pu >= panic && scale > SCALE_ONE) begin
               scale = SCALE_ONE;
               impose_ceiling(scale);
               word.flags.primary_emergency = 1'b1;
            end else if (pu >= alarm && scale > SCALE_ONE) begin
               scale = lower_scale(scale);
               impose_ceiling(scale);
               word.flags.primary_step = 1'b1;
            end
         end
      end
      word.scale_out = scale;
      word.ceiling_value = no_ceiling ? 16'd0 : ceiling;
      word.ceiling_unset = no_ceiling;
      word.primary_peak = pri_peak;
      word.secondary_peak = sec_peak;
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] rsp mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pri_enable = 1'b0;
         sec_enable = 1'b0;
         pri_limit = PRI_LIMIT_MIN;
         sec_limit = SEC_LIMIT_MIN;
         overflow_seen = 1'b0;
         sec_full_seen = 1'b0;
         pri_peak = '0;
         sec_peak = '0;
         ceiling = '0;
         no_ceiling = 1'b1;
         mismatches = 0;
         expected_throttle.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PRIMARY_ENABLE:   pri_enable = csr_write_data[0];
               CSR_SECONDARY_ENABLE: sec_enable = csr_write_data[0];
               CSR_PRIMARY_LIMIT: begin
                  if (csr_write_data[17:0] >= PRI_LIMIT_MIN) pri_limit = csr_write_data[17:0];
               end
               CSR_SECONDARY_LIMIT: begin
                  if (csr_write_data >= SEC_LIMIT_MIN) sec_limit = csr_write_data;
               end
               default: ;
            endcase
         end
         // check the outgoing word first: it always belongs to an older word
         if (rsp_valid && !rsp_stall) begin
            if (expected_throttle.size() == 0) begin
               report_mismatch("result word with nothing outstanding");
            end else begin
               oldest = expected_throttle.pop_front();
               check_field("scale_out", 32'(rsp_scale_out), 32'(oldest.scale_out));
               check_field("ceiling_value", 32'(rsp_ceiling_value),
                           32'(oldest.ceiling_value));
               check_field("ceiling_unset", 32'(rsp_ceiling_unset),
                           32'(oldest.ceiling_unset));
               check_field("primary_peak", rsp_primary_peak, oldest.primary_peak);
               check_field("secondary_peak", 32'(rsp_secondary_peak),
                           32'(oldest.secondary_peak));
               check_field("primary_over_limit", 32'(rsp_primary_over_limit),
                           32'(oldest.flags.primary_over_limit));
               check_field("overflow_first", 32'(rsp_overflow_first),
                           32'(oldest.flags.overflow_first));
               check_field("secondary_full_first", 32'(rsp_secondary_full_first),
                           32'(oldest.flags.secondary_full_first));
               check_field("secondary_step", 32'(rsp_secondary_step),
                           32'(oldest.flags.secondary_step));
               check_field("primary_emergency", 32'(rsp_primary_emergency),
                           32'(oldest.flags.primary_emergency));
               check_field("primary_step", 32'(rsp_primary_step),
                           32'(oldest.flags.primary_step));
            end
         end
         if (req_valid && !req_stall) begin
            predict_throttle(req_cmd, req_primary_used, req_secondary_used, req_scale_in,
                             predicted);
            expected_throttle.push_back(predicted);
         end
      end
      pending = expected_throttle.size();
   end

endmodule

FILE: sim/tb_occupancy_watchdog_throttle.sv
`timescale 1ns / 1ps

module tb_occupancy_watchdog_throttle;

   import owt_pkg::*;

   // Number of phases of random traffic and words per phase.
   localparam int PHASES = 8;
   localparam int PHASE_WORDS = 205;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CMD_TICK;
   logic [31:0] req_primary_used = '0;
   logic [31:0] req_secondary_used = '0;
   logic [15:0] req_scale_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_scale_out;
   logic [15:0] rsp_ceiling_value;
   logic        rsp_ceiling_unset;
   logic [31:0] rsp_primary_peak;
   logic [20:0] rsp_secondary_peak;
   logic        rsp_primary_over_limit;
   logic        rsp_overflow_first;
   logic        rsp_secondary_full_first;
   logic        rsp_secondary_step;
   logic        rsp_primary_emergency;
   logic        rsp_primary_step;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_PRIMARY_ENABLE;
   logic [18:0] csr_write_data = '0;

   int unsigned mismatches;
   int unsigned pending;

   // Idling switches, flipped every few dozen words so that some stretches
   // run back to back and others are full of gaps and stalls.
   logic        gap_on = 1'b0;
   logic        stall_on = 1'b0;
   int unsigned rsp_hold = 0;

   // Effective limits as the block should hold them; used to aim the counts.
   logic [17:0] cur_plimit = PRI_LIMIT_MIN;
   logic [18:0] cur_slimit = SEC_LIMIT_MIN;

   always #6 clock = ~clock;

   occupancy_watchdog_throttle dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_cmd                 (req_cmd),
      .req_primary_used        (req_primary_used),
      .req_secondary_used      (req_secondary_used),
      .req_scale_in            (req_scale_in),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_scale_out           (rsp_scale_out),
      .rsp_ceiling_value       (rsp_ceiling_value),
      .rsp_ceiling_unset       (rsp_ceiling_unset),
      .rsp_primary_peak        (rsp_primary_peak),
      .rsp_secondary_peak      (rsp_secondary_peak),
      .rsp_primary_over_limit  (rsp_primary_over_limit),
      .rsp_overflow_first      (rsp_overflow_first),
      .rsp_secondary_full_first(rsp_secondary_full_first),
      .rsp_secondary_step      (rsp_secondary_step),
      .rsp_primary_emergency   (rsp_primary_emergency),
      .rsp_primary_step        (rsp_primary_step),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data)
   );

   owt_result_check result_check (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_cmd                 (req_cmd),
      .req_primary_used        (req_primary_used),
      .req_secondary_used      (req_secondary_used),
      .req_scale_in            (req_scale_in),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_scale_out           (rsp_scale_out),
      .rsp_ceiling_value       (rsp_ceiling_value),
      .rsp_ceiling_unset       (rsp_ceiling_unset),
      .rsp_primary_peak        (rsp_primary_peak),
      .rsp_secondary_peak      (rsp_secondary_peak),
      .rsp_primary_over_limit  (rsp_primary_over_limit),
      .rsp_overflow_first      (rsp_overflow_first),
      .rsp_secondary_full_first(rsp_secondary_full_first),
      .rsp_secondary_step      (rsp_secondary_step),
      .rsp_primary_emergency   (rsp_primary_emergency),
      .rsp_primary_step        (rsp_primary_step),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data),
      .mismatches              (mismatches),
      .pending                 (pending)
   );

   // Result side: after each accepted result word, draw how many cycles to
   // hold off the next one. Stall only while a word is actually waiting.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) rsp_hold = stall_on ? $urandom_range(0, 4) : 0;
   end

   always @(negedge clock) begin
      if (rsp_valid === 1'b1 && rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one word and hold it until taken. Call at a falling edge; returns
   // at the falling edge after acceptance with valid still high, so a
   // following word goes out back to back without a glitch on valid.
   task automatic send_word(input logic cmd, input logic [31:0] pu, input logic [31:0] su,
                            input logic [15:0] scale);
      int unsigned gap;
      gap = gap_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_primary_used <= pu;
      req_secondary_used <= su;
      req_scale_in <= scale;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid, wait for every outstanding word to come back, then let the
   // two pipeline stages settle before touching the registers.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Write all four registers on consecutive edges, write enable held high.
   task automatic program_regs(input logic [18:0] pri_on, input logic [18:0] sec_on,
                               input logic [18:0] pri_lim, input logic [18:0] sec_lim);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_PRIMARY_ENABLE;
      csr_write_data <= pri_on;
      @(negedge clock);
      csr_index <= CSR_SECONDARY_ENABLE;
      csr_write_data <= sec_on;
      @(negedge clock);
      csr_index <= CSR_PRIMARY_LIMIT;
      csr_write_data <= pri_lim;
      @(negedge clock);
      csr_index <= CSR_SECONDARY_LIMIT;
      csr_write_data <= sec_lim;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      // writes below the minimum are dropped by the block
      if (pri_lim[17:0] >= PRI_LIMIT_MIN) cur_plimit = pri_lim[17:0];
      if (sec_lim >= SEC_LIMIT_MIN) cur_slimit = sec_lim;
   endtask

   function automatic logic [31:0] around(input logic [31:0] c);
      return c + 32'($urandom_range(0, 4)) - 32'd2;
   endfunction

   // Aim counts and scale at the thresholds of the current setting most of
   // the time, with fully random words mixed in to toggle every bit.
   task automatic send_random_word();
      logic [31:0] plim;
      logic [31:0] slim;
      logic [31:0] alarm;
      logic [31:0] panic;
      logic [31:0] salarm;
      logic [31:0] pu;
      logic [31:0] su;
      logic [15:0] scale;
      logic        cmd;
      plim = 32'(cur_plimit);
      slim = 32'(cur_slimit);
      alarm = (plim >> PRI_BASE_SHIFT) * 32'(PRI_ALARM_UNIT);
      panic = (plim >> PRI_BASE_SHIFT) * 32'(PRI_PANIC_UNIT);
      salarm = (slim * 32'd3) >> 2;
      cmd = ($urandom_range(0, 15) == 0) ? CMD_CLEAR : CMD_TICK;
      case ($urandom_range(0, 9))
         0: pu = $urandom_range(0, alarm);
         1: pu = around(alarm);
         2: pu = $urandom_range(alarm, panic);
         3: pu = around(panic);
         4: pu = around(plim);
         5: pu = $urandom_range(panic, plim);
         6: pu = $urandom_range(plim + 1, plim * 8);
         7: pu = around(PEAK_BOUND);
         8: pu = $urandom();
         default: pu = $urandom_range(0, plim);
      endcase
      case ($urandom_range(0, 7))
         0: su = $urandom_range(0, salarm);
         1: su = around(salarm);
         2: su = $urandom_range(salarm, slim);
         3: su = around(slim);
         4: su = around(slim * 4);
         5: su = $urandom_range(slim, slim * 4);
         6: su = $urandom();
         default: su = $urandom_range(0, slim * 4);
      endcase
      case ($urandom_range(0, 6))
         0: scale = 16'(around(32'(SCALE_ONE)));
         1: scale = 16'(around(32'(SCALE_ONE + SCALE_STEP)));
         2: scale = 16'($urandom_range(0, SCALE_ONE));
         3: scale = 16'hFFFF - 16'($urandom_range(0, 2));
         4: scale = 16'($urandom());
         default: scale = 16'($urandom_range(SCALE_ONE + 1, 16'hFFFF));
      endcase
      send_word(cmd, pu, su, scale);
   endtask

   initial begin
      logic [18:0] pri_on;
      logic [18:0] sec_on;
      logic [18:0] pri_lim;
      logic [18:0] sec_lim;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Watch disabled after reset: words pass the scale through untouched.
      send_word(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(CMD_CLEAR, 32'd0, 32'd0, 16'h1234);
      wait_idle();

      // Minimum limits: primary alarm 0x1600, panic 0x1D00, secondary
      // alarm 12288, implausible above 65536.
      program_regs(19'd1, 19'd1, 19'(PRI_LIMIT_MIN), 19'(SEC_LIMIT_MIN));
      send_word(CMD_TICK, 32'd0, 32'd0, 16'd0);
      // primary alarm steps a full scale down
      send_word(CMD_TICK, 32'h1600, 32'd0, 16'hFFFF);
      // primary panic clamps just above one
      send_word(CMD_TICK, 32'h1D00, 32'd0, SCALE_ONE + 16'd1);
      // a step that would undershoot lands on one
      send_word(CMD_TICK, 32'd6000, 32'd0, SCALE_ONE + SCALE_STEP);
      // scale at one is never stepped
      send_word(CMD_TICK, 32'd6000, 32'd0, SCALE_ONE);
      send_word(CMD_TICK, 32'd5631, 32'd0, 16'd9000);
      // secondary alarm step
      send_word(CMD_TICK, 32'd0, 32'd12288, 16'd20000);
      // secondary full forces one even from below one; the primary alarm then finds one and does not step
      send_word(CMD_TICK, 32'h1600, 32'd16384, 16'd4000);
      // secondary full a second time: only the alarm step, then a primary step
      send_word(CMD_TICK, 32'h1600, 32'd20000, 16'd30000);
      // secondary at exactly four times its limit still counts
      send_word(CMD_TICK, 32'd0, 32'd65536, 16'd30000);
      // implausible secondary counts are ignored outright
      send_word(CMD_TICK, 32'd0, 32'd65537, 16'd30000);
      send_word(CMD_TICK, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      // primary over limit: first overflow, clamp, peak
      send_word(CMD_TICK, 32'd8193, 32'd0, 16'hFFFF);
      send_word(CMD_TICK, PEAK_BOUND - 32'd1, 32'd0, 16'd100);
      // at and above the peak bound the peak holds
      send_word(CMD_TICK, PEAK_BOUND, 32'd0, SCALE_ONE + 16'd1);
      send_word(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
      // count equal to the limit is not over it and hits the panic level
      send_word(CMD_TICK, 32'd8192, 32'd0, 16'hFFFF);
      send_word(CMD_CLEAR, 32'd0, 32'd0, 16'd0);
      send_word(CMD_TICK, 32'd7423, 32'd0, 16'd9000);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         pri_on = 19'($urandom());
         sec_on = 19'($urandom());
         pri_on[0] = ($urandom_range(0, 4) != 0);
         sec_on[0] = ($urandom_range(0, 3) != 0);
         pri_lim = 19'($urandom_range(PRI_LIMIT_MIN, 19'h7FFFF));
         sec_lim = 19'($urandom_range(SEC_LIMIT_MIN, 19'h7FFFF));
         case (phase)
            0: begin
               // just below the minimum: both writes dropped
               pri_on = 19'd1;
               sec_on = 19'd1;
               pri_lim = 19'(PRI_LIMIT_MIN) - 19'd1;
               sec_lim = 19'(SEC_LIMIT_MIN) - 19'd1;
            end
            1: begin
               // largest limits; bit 18 of the primary write falls away
               pri_on = 19'h7FFFF;
               sec_on = 19'h7FFFF;
               pri_lim = 19'h7FFFF;
               sec_lim = 19'h7FFFF;
            end
            2: pri_on = 19'h7FFFE;
            3: sec_on = 19'd0;
            4: begin
               // primary limit truncates to zero and secondary is zero
               pri_on = 19'd1;
               sec_on = 19'd1;
               pri_lim = 19'h40000;
               sec_lim = 19'd0;
            end
            5: begin
               pri_lim = 19'(PRI_LIMIT_MIN);
               sec_lim = 19'(SEC_LIMIT_MIN);
            end
            default: ;
         endcase
         program_regs(pri_on, sec_on, pri_lim, sec_lim);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 41 == 0) begin
               gap_on = ($urandom_range(0, 3) != 0);
               stall_on = ($urandom_range(0, 3) != 0);
            end
            send_random_word();
         end
      end

      wait_idle();
      if (mismatches == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/owt_pkg.sv
hdl/occupancy_watchdog_throttle.sv
sim/owt_result_check.sv
sim/tb_occupancy_watchdog_throttle.sv
